// ===== rtl/core/pfd_pkg.sv =====
// shared types, widths and register codes of the potential field direction core
package pfd_pkg;

  localparam int MAX_REPULSORS_DEFAULT = 4;
  localparam int NUM_REP_REGS = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W = 16;
  localparam int REP_W = 32;
  localparam int COUNT_W = 3;
  localparam int RAD_W = 15;
  localparam int RAD2_W = 30;

  localparam int DIFF_W = 17;
  localparam int MAG_W = 16;
  localparam int SQ_W = 32;
  localparam int DIST_W = 33;
  localparam int TERM_SHIFT = 34;
  localparam int TERM_NUM_W = MAG_W + TERM_SHIFT;
  localparam int TERM_Q_W = 35;
  localparam int SUM_W = 38;
  localparam int SUM_MAG_W = SUM_W - 1;
  localparam int NORM_W = 30;
  localparam int SHIFT_W = 3;
  localparam int Q_W = 62;
  localparam int ROOT_W = Q_W / 2;
  localparam int DIR_SHIFT = 14;
  localparam int DIR_NUM_W = NORM_W + DIR_SHIFT;
  localparam int DIR_Q_W = 15;
  localparam int DIR_W = 16;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 15'd800;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REP_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REP_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REP_COUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL_RADIUS = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic degenerate;
  } out_word_t;

  typedef struct packed {
    logic degen;
    logic neg_x;
    logic neg_y;
    logic [NORM_W-1:0] mx;
    logic [NORM_W-1:0] my;
  } norm_side_t;

endpackage

// ===== rtl/core/pfd_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
module pfd_div_pipe #(
  parameter int LANES = 2,
  parameter int NUM_W = 44,
  parameter int DEN_W = 31,
  parameter int QUO_W = 15,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [LANES-1:0][DEN_W-1:0] den,
  input  logic [SIDE_W-1:0] side,
  output logic out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [SIDE_W-1:0] out_side
);

  logic v [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] den_r [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] nlo_r [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_r [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic src_v;
    logic [LANES-1:0][DEN_W-1:0] src_rem;
    logic [LANES-1:0][DEN_W-1:0] src_den;
    logic [LANES-1:0][QUO_W-1:0] src_nlo;
    logic [LANES-1:0][QUO_W-1:0] src_quo;
    logic [SIDE_W-1:0] src_side;
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0][QUO_W-1:0] nlo_next;
    logic [LANES-1:0][QUO_W-1:0] quo_next;

    if (k == 0) begin : g_first
      always_comb begin
        src_v = in_valid;
        src_den = den;
        src_side = side;
        for (int l = 0; l < LANES; l++) begin
          src_rem[l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
          src_nlo[l] = num[l][QUO_W-1:0];
          src_quo[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        src_v = v[k-1];
        src_rem = rem_r[k-1];
        src_den = den_r[k-1];
        src_nlo = nlo_r[k-1];
        src_quo = quo_r[k-1];
        src_side = side_r[k-1];
      end
    end

    always_comb begin
      logic [DEN_W:0] cand;
      logic ge;
      for (int l = 0; l < LANES; l++) begin
        cand = {src_rem[l], src_nlo[l][QUO_W-1]};
        ge = (cand >= {1'b0, src_den[l]});
        rem_next[l] = ge ? DEN_W'(cand - {1'b0, src_den[l]}) : cand[DEN_W-1:0];
        nlo_next[l] = {src_nlo[l][QUO_W-2:0], 1'b0};
        quo_next[l] = {src_quo[l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_next;
        den_r[k] <= src_den;
        nlo_r[k] <= nlo_next;
        quo_r[k] <= quo_next;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v[QUO_W-1];
  assign quo = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

// ===== rtl/core/pfd_isqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
module pfd_isqrt_pipe #(
  parameter int QW = 62,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [QW-1:0] q,
  input  logic [SIDE_W-1:0] side,
  output logic out_valid,
  output logic [QW/2-1:0] root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NSTG = QW / 2;

  logic v [NSTG];
  logic [QW-1:0] q_r [NSTG];
  logic [QW-1:0] res_r [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam logic [QW-1:0] BIT = {{(QW-1){1'b0}}, 1'b1} << (QW - 2 - 2 * k);
    logic src_v;
    logic [QW-1:0] src_q;
    logic [QW-1:0] src_res;
    logic [SIDE_W-1:0] src_side;
    logic [QW-1:0] trial;
    logic [QW-1:0] q_next;
    logic [QW-1:0] res_next;

    if (k == 0) begin : g_first
      always_comb begin
        src_v = in_valid;
        src_q = q;
        src_res = '0;
        src_side = side;
      end
    end else begin : g_next
      always_comb begin
        src_v = v[k-1];
        src_q = q_r[k-1];
        src_res = res_r[k-1];
        src_side = side_r[k-1];
      end
    end

    always_comb begin
      trial = src_res + BIT;
      if (src_q >= trial) begin
        q_next = src_q - trial;
        res_next = (src_res >> 1) + BIT;
      end else begin
        q_next = src_q;
        res_next = src_res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_next;
        res_r[k] <= res_next;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v[NSTG-1];
  assign root = res_r[NSTG-1][QW/2-1:0];
  assign out_side = side_r[NSTG-1];

endmodule

// ===== rtl/core/pfd_front.sv =====
// coordinate differences, squared distances and term selection ahead of the dividers
module pfd_front #(
  parameter int NREP = pfd_pkg::MAX_REPULSORS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  pfd_pkg::in_word_t in_word,
  input  logic signed [pfd_pkg::COORD_W-1:0] target_x,
  input  logic signed [pfd_pkg::COORD_W-1:0] target_y,
  input  logic [NREP-1:0][pfd_pkg::REP_W-1:0] rep_xy,
  input  logic [pfd_pkg::COUNT_W-1:0] rep_count,
  input  logic [pfd_pkg::RAD2_W-1:0] rad2,
  output logic c_valid,
  output logic [2*(NREP+1)-1:0][pfd_pkg::TERM_NUM_W-1:0] num,
  output logic [2*(NREP+1)-1:0][pfd_pkg::DIST_W-1:0] den,
  output logic [3*(NREP+1):0] side
);
  import pfd_pkg::*;

  localparam int LANES = NREP + 1;

  logic signed [COORD_W-1:0] ox [LANES];
  logic signed [COORD_W-1:0] oy [LANES];
  logic signed [DIFF_W-1:0] dx_next [LANES];
  logic signed [DIFF_W-1:0] dy_next [LANES];

  logic a_valid;
  logic signed [DIFF_W-1:0] a_dx [LANES];
  logic signed [DIFF_W-1:0] a_dy [LANES];

  logic signed [2*DIFF_W-1:0] pxx [LANES];
  logic signed [2*DIFF_W-1:0] pyy [LANES];

  logic b_valid;
  logic [SQ_W-1:0] b_sqx [LANES];
  logic [SQ_W-1:0] b_sqy [LANES];
  logic signed [DIFF_W-1:0] b_dx [LANES];
  logic signed [DIFF_W-1:0] b_dy [LANES];

  logic [2*LANES-1:0][TERM_NUM_W-1:0] num_next;
  logic [2*LANES-1:0][DIST_W-1:0] den_next;
  logic [3*LANES:0] side_next;

  // lane 0 attracts toward the target, the others push away from repulsors
  always_comb begin
    ox[0] = target_x;
    oy[0] = target_y;
    for (int l = 1; l < LANES; l++) begin
      ox[l] = rep_xy[l-1][COORD_W-1:0];
      oy[l] = rep_xy[l-1][REP_W-1:COORD_W];
    end
    dx_next[0] = DIFF_W'(ox[0]) - DIFF_W'(in_word.query_x);
    dy_next[0] = DIFF_W'(oy[0]) - DIFF_W'(in_word.query_y);
    for (int l = 1; l < LANES; l++) begin
      dx_next[l] = DIFF_W'(in_word.query_x) - DIFF_W'(ox[l]);
      dy_next[l] = DIFF_W'(in_word.query_y) - DIFF_W'(oy[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pxx[l] = a_dx[l] * a_dx[l];
      pyy[l] = a_dy[l] * a_dy[l];
    end
  end

  always_comb begin
    logic [DIST_W-1:0] s;
    logic act;
    logic nx;
    logic ny;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    side_next = '0;
    side_next[0] = (b_dx[0] == '0) && (b_dy[0] == '0);
    for (int l = 0; l < LANES; l++) begin
      s = DIST_W'(b_sqx[l]) + DIST_W'(b_sqy[l]);
      if (l == 0) begin
        act = (s != '0);
      end else begin
        act = (s != '0) && (s < DIST_W'(rad2)) && (COUNT_W'(l - 1) < rep_count);
      end
      nx = b_dx[l][DIFF_W-1];
      ny = b_dy[l][DIFF_W-1];
      mx = MAG_W'(nx ? -b_dx[l] : b_dx[l]);
      my = MAG_W'(ny ? -b_dy[l] : b_dy[l]);
      num_next[l] = {mx, {TERM_SHIFT{1'b0}}};
      num_next[LANES+l] = {my, {TERM_SHIFT{1'b0}}};
      den_next[l] = s;
      den_next[LANES+l] = s;
      side_next[1+l] = act;
      side_next[1+LANES+l] = nx;
      side_next[1+2*LANES+l] = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= dx_next;
      a_dy <= dy_next;
      for (int l = 0; l < LANES; l++) begin
        b_sqx[l] <= pxx[l][SQ_W-1:0];
        b_sqy[l] <= pyy[l][SQ_W-1:0];
      end
      b_dx <= a_dx;
      b_dy <= a_dy;
      num <= num_next;
      den <= den_next;
      side <= side_next;
    end
  end

endmodule

// ===== rtl/core/pfd_norm.sv =====
// term signs, field sum, magnitude scaling and squared length
module pfd_norm #(
  parameter int NREP = pfd_pkg::MAX_REPULSORS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2*(NREP+1)-1:0][pfd_pkg::TERM_Q_W-1:0] quo,
  input  logic [3*(NREP+1):0] side,
  output logic out_valid,
  output logic [pfd_pkg::Q_W-1:0] qsum,
  output pfd_pkg::norm_side_t out_side
);
  import pfd_pkg::*;

  localparam int LANES = NREP + 1;

  logic t_valid;
  logic t_tgt_eq;
  logic signed [SUM_W-1:0] t_term [2*LANES];
  logic signed [SUM_W-1:0] term_next [2*LANES];

  logic s_valid;
  logic s_tgt_eq;
  logic signed [SUM_W-1:0] s_x;
  logic signed [SUM_W-1:0] s_y;
  logic signed [SUM_W-1:0] sum_x_next;
  logic signed [SUM_W-1:0] sum_y_next;

  logic m_valid;
  logic m_degen;
  logic m_nx;
  logic m_ny;
  logic [SUM_MAG_W-1:0] m_x;
  logic [SUM_MAG_W-1:0] m_y;

  logic n_valid;
  logic n_degen;
  logic n_nx;
  logic n_ny;
  logic [NORM_W-1:0] n_x;
  logic [NORM_W-1:0] n_y;
  logic [SHIFT_W-1:0] shamt;
  logic [SUM_MAG_W-1:0] m_or;

  logic p_valid;
  logic p_degen;
  logic p_nx;
  logic p_ny;
  logic [NORM_W-1:0] p_x;
  logic [NORM_W-1:0] p_y;
  logic [2*NORM_W-1:0] p_sqx;
  logic [2*NORM_W-1:0] p_sqy;

  always_comb begin
    logic signed [SUM_W-1:0] ext;
    for (int l = 0; l < LANES; l++) begin
      ext = SUM_W'(quo[l]);
      term_next[l] = !side[1+l] ? '0 : (side[1+LANES+l] ? -ext : ext);
      ext = SUM_W'(quo[LANES+l]);
      term_next[LANES+l] = !side[1+l] ? '0 : (side[1+2*LANES+l] ? -ext : ext);
    end
  end

  always_comb begin
    sum_x_next = '0;
    sum_y_next = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_x_next = sum_x_next + t_term[l];
      sum_y_next = sum_y_next + t_term[LANES+l];
    end
  end

  // scale down until both magnitudes fit below 2^30
  always_comb begin
    m_or = m_x | m_y;
    shamt = '0;
    for (int j = NORM_W; j < SUM_MAG_W; j++) begin
      if (m_or[j]) begin
        shamt = SHIFT_W'(j - NORM_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      s_valid <= 1'b0;
      m_valid <= 1'b0;
      n_valid <= 1'b0;
      p_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      t_valid <= in_valid;
      s_valid <= t_valid;
      m_valid <= s_valid;
      n_valid <= m_valid;
      p_valid <= n_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_term <= term_next;
      t_tgt_eq <= side[0];

      s_x <= sum_x_next;
      s_y <= sum_y_next;
      s_tgt_eq <= t_tgt_eq;

      m_degen <= s_tgt_eq || ((s_x == '0) && (s_y == '0));
      m_nx <= s_x[SUM_W-1];
      m_ny <= s_y[SUM_W-1];
      m_x <= SUM_MAG_W'(s_x[SUM_W-1] ? -s_x : s_x);
      m_y <= SUM_MAG_W'(s_y[SUM_W-1] ? -s_y : s_y);

      n_degen <= m_degen;
      n_nx <= m_nx;
      n_ny <= m_ny;
      n_x <= NORM_W'(m_x >> shamt);
      n_y <= NORM_W'(m_y >> shamt);

      p_degen <= n_degen;
      p_nx <= n_nx;
      p_ny <= n_ny;
      p_x <= n_x;
      p_y <= n_y;
      p_sqx <= n_x * n_x;
      p_sqy <= n_y * n_y;

      qsum <= Q_W'(p_sqx) + Q_W'(p_sqy);
      out_side.degen <= p_degen;
      out_side.neg_x <= p_nx;
      out_side.neg_y <= p_ny;
      out_side.mx <= p_x;
      out_side.my <= p_y;
    end
  end

endmodule

// ===== rtl/core/potential_field_direction_core.sv =====
// top level of the potential field direction core: registers, pipeline and output buffer
//
// Takes one query point per cycle while in_stall is low and returns its unit steering
// direction in Q1.14 through 3 front stages, 35 stages of the term dividers (one
// quotient bit per stage), 6 summing and scaling stages, 31 square root stages, 15
// stages of the final divider and the output register. The whole pipeline advances
// together and holds when the output word and the one-word skid buffer behind it are
// both waiting; in_stall is the registered state of that skid buffer, so a stalled
// consumer costs at most one extra word of buffering. Only the first MAX_REPULSORS
// (at most NUM_REP_REGS) repulsor registers exist. Degenerate queries (point on the
// target or a zero field sum) return a zero direction with degenerate set.
module potential_field_direction_core #(
  parameter int MAX_REPULSORS = pfd_pkg::MAX_REPULSORS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  pfd_pkg::in_word_t in_word,
  output logic out_valid,
  input  logic out_stall,
  output pfd_pkg::out_word_t out_word
);
  import pfd_pkg::*;

  localparam int NREP = (MAX_REPULSORS < NUM_REP_REGS) ? MAX_REPULSORS : NUM_REP_REGS;
  localparam int LANES = NREP + 1;
  localparam int SIDE_W = $bits(norm_side_t);

  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [NREP-1:0][REP_W-1:0] rep_xy;
  logic [COUNT_W-1:0] rep_count;
  logic [RAD_W-1:0] repel_radius;
  logic [RAD2_W-1:0] rad2;

  logic en;

  logic c_valid;
  logic [2*LANES-1:0][TERM_NUM_W-1:0] c_num;
  logic [2*LANES-1:0][DIST_W-1:0] c_den;
  logic [3*LANES:0] c_side;

  logic d_valid;
  logic [2*LANES-1:0][TERM_Q_W-1:0] d_quo;
  logic [3*LANES:0] d_side;

  logic n_valid;
  logic [Q_W-1:0] n_q;
  norm_side_t n_side;

  logic r_valid;
  logic [ROOT_W-1:0] r_root;
  norm_side_t r_side;

  logic f_valid;
  logic [1:0][DIR_Q_W-1:0] f_quo;
  norm_side_t f_side;

  out_word_t p_word;
  logic skid_valid;
  out_word_t skid_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      rep_xy <= '0;
      rep_count <= '0;
      repel_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X: target_x <= cfg_data[COORD_W-1:0];
        REG_TARGET_Y: target_y <= cfg_data[COORD_W-1:0];
        REG_REP_COUNT: rep_count <= cfg_data[COUNT_W-1:0];
        REG_REPEL_RADIUS: repel_radius <= cfg_data[RAD_W-1:0];
        default: begin
          for (int i = 0; i < NREP; i++) begin
            if (cfg_index == REG_REP_A + CFG_IDX_W'(i)) begin
              rep_xy[i] <= cfg_data[REP_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rad2 <= repel_radius * repel_radius;
  end

  assign en = ~skid_valid;
  assign in_stall = skid_valid;

  pfd_front #(.NREP(NREP)) u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .in_word(in_word),
    .target_x(target_x),
    .target_y(target_y),
    .rep_xy(rep_xy),
    .rep_count(rep_count),
    .rad2(rad2),
    .c_valid(c_valid),
    .num(c_num),
    .den(c_den),
    .side(c_side)
  );

  pfd_div_pipe #(
    .LANES(2 * LANES),
    .NUM_W(TERM_NUM_W),
    .DEN_W(DIST_W),
    .QUO_W(TERM_Q_W),
    .SIDE_W(3 * LANES + 1)
  ) u_term_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(c_valid),
    .num(c_num),
    .den(c_den),
    .side(c_side),
    .out_valid(d_valid),
    .quo(d_quo),
    .out_side(d_side)
  );

  pfd_norm #(.NREP(NREP)) u_norm (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(d_valid),
    .quo(d_quo),
    .side(d_side),
    .out_valid(n_valid),
    .qsum(n_q),
    .out_side(n_side)
  );

  pfd_isqrt_pipe #(.QW(Q_W), .SIDE_W(SIDE_W)) u_isqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(n_valid),
    .q(n_q),
    .side(n_side),
    .out_valid(r_valid),
    .root(r_root),
    .out_side(r_side)
  );

  pfd_div_pipe #(
    .LANES(2),
    .NUM_W(DIR_NUM_W),
    .DEN_W(ROOT_W),
    .QUO_W(DIR_Q_W),
    .SIDE_W(SIDE_W)
  ) u_dir_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(r_valid),
    .num({{r_side.my, {DIR_SHIFT{1'b0}}}, {r_side.mx, {DIR_SHIFT{1'b0}}}}),
    .den({r_root, r_root}),
    .side(r_side),
    .out_valid(f_valid),
    .quo(f_quo),
    .out_side(f_side)
  );

  always_comb begin
    if (f_side.degen) begin
      p_word.dir_x = '0;
      p_word.dir_y = '0;
    end else begin
      p_word.dir_x = f_side.neg_x ? -DIR_W'(f_quo[0]) : DIR_W'(f_quo[0]);
      p_word.dir_y = f_side.neg_y ? -DIR_W'(f_quo[1]) : DIR_W'(f_quo[1]);
    end
    p_word.degenerate = f_side.degen;
  end

  // output word with a one-word skid buffer behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (en && f_valid) begin
        skid_valid <= 1'b1;
        skid_word <= p_word;
      end
    end else if (skid_valid) begin
      out_valid <= 1'b1;
      out_word <= skid_word;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= f_valid;
      out_word <= p_word;
    end
  end

endmodule

// ===== tb/potential_field_direction_core_tb.sv =====
// testbench of the potential field direction core: checks every steering word against a predictor
`timescale 1ns / 100ps

module potential_field_direction_core_tb;
  import pfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  potential_field_direction_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #1 clk = ~clk;

  // register copies
  logic signed [COORD_W-1:0] tgt_x, tgt_y;
  logic [REP_W-1:0] rep_xy [NUM_REP_REGS];
  logic [COUNT_W-1:0] rep_count;
  logic [RAD_W-1:0] repel_rad;

  in_word_t query_queue[$];
  out_word_t dir_queue[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit send_pause = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic out_word_t steer_dir(in_word_t w);
    longint px, py, dx, dy, s, sx, sy, r2;
    longint unsigned mx, my, q, res, bt, ox, oy, vx, vy;
    int n;
    out_word_t o;
    o = '0;
    o.degenerate = 1'b1;
    px = w.query_x;
    py = w.query_y;
    dx = longint'(tgt_x) - px;
    dy = longint'(tgt_y) - py;
    if (dx == 0 && dy == 0) return o;
    s = dx * dx + dy * dy;
    sx = (dx * 64'sd17179869184) / s;
    sy = (dy * 64'sd17179869184) / s;
    n = rep_count;
    if (n > NUM_REP_REGS) n = NUM_REP_REGS;
    r2 = longint'(repel_rad) * longint'(repel_rad);
    for (int i = 0; i < n; i++) begin
      dx = px - longint'($signed(rep_xy[i][15:0]));
      dy = py - longint'($signed(rep_xy[i][31:16]));
      s = dx * dx + dy * dy;
      if (s != 0 && s < r2) begin
        sx += (dx * 64'sd17179869184) / s;
        sy += (dy * 64'sd17179869184) / s;
      end
    end
    if (sx == 0 && sy == 0) return o;
    mx = sx < 0 ? -sx : sx;
    my = sy < 0 ? -sy : sy;
    while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
      mx >>= 1;
      my >>= 1;
    end
    q = mx * mx + my * my;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > q) bt >>= 2;
    while (bt != 0) begin
      if (q >= res + bt) begin
        q -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    if (res == 0) return o;
    ox = (mx * 16384) / res;
    oy = (my * 16384) / res;
    vx = sx < 0 ? -ox : ox;
    vy = sy < 0 ? -oy : oy;
    o.dir_x = vx[15:0];
    o.dir_y = vy[15:0];
    o.degenerate = 1'b0;
    return o;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) dir_queue.push_back(steer_dir(in_word));
      if (send_pause || query_queue.size() == 0 ||
          $urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word <= query_queue.pop_front();
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dir_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word %h", out_word);
        end else begin
          exp_w = dir_queue.pop_front();
          if (exp_w.dir_x !== out_word.dir_x || exp_w.dir_y !== out_word.dir_y ||
              exp_w.degenerate !== out_word.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x %0d y %0d degen %0d, got x %0d y %0d degen %0d",
                       exp_w.dir_x, exp_w.dir_y, exp_w.degenerate,
                       out_word.dir_x, out_word.dir_y, out_word.degenerate);
          end
        end
      end
      if (hold_request && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < recv_idle_pct;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("potential_field_direction_core_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TARGET_X: tgt_x = val[15:0];
      REG_TARGET_Y: tgt_y = val[15:0];
      REG_REP_A: rep_xy[0] = val;
      REG_REP_B: rep_xy[1] = val;
      REG_REP_C: rep_xy[2] = val;
      REG_REP_D: rep_xy[3] = val;
      REG_REP_COUNT: rep_count = val[2:0];
      REG_REPEL_RADIUS: repel_rad = val[14:0];
      default: ;
    endcase
  endtask

  task automatic reg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (query_queue.size() != 0 || in_valid || dir_queue.size() != 0) @(posedge clk);
  endtask

  task automatic add_query(input int x, input int y);
    in_word_t w;
    w.query_x = x[15:0];
    w.query_y = y[15:0];
    query_queue.push_back(w);
  endtask

  function automatic int near(input int c, input int span);
    return c + $urandom_range(2 * span) - span;
  endfunction

  task automatic random_config(input int cnt, input int rad);
    int tx, ty;
    tx = $urandom_range(8000) - 4000;
    ty = $urandom_range(8000) - 4000;
    reg_write(REG_TARGET_X, {16'($urandom_range(65535)), tx[15:0]});
    reg_write(REG_TARGET_Y, {16'($urandom_range(65535)), ty[15:0]});
    for (int i = 0; i < NUM_REP_REGS; i++)
      reg_write(REG_REP_A + CFG_IDX_W'(i), {16'(near(ty, 1500)), 16'(near(tx, 1500))});
    reg_write(REG_REP_COUNT, {29'($urandom), cnt[2:0]});
    reg_write(REG_REPEL_RADIUS, {16'($urandom_range(65535)), 1'b0, rad[14:0]});
    reg_done();
  endtask

  task automatic random_queries(input int num);
    int pick, k;
    for (int i = 0; i < num; i++) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        k = $urandom_range(NUM_REP_REGS - 1);
        add_query(near($signed(rep_xy[k][15:0]), 900), near($signed(rep_xy[k][31:16]), 900));
      end else if (pick < 7) begin
        add_query(near(tgt_x, 300), near(tgt_y, 300));
      end else if (pick == 7) begin
        k = $urandom_range(NUM_REP_REGS - 1);
        if (pick[0]) add_query($signed(rep_xy[k][15:0]), $signed(rep_xy[k][31:16]));
        else add_query(tgt_x, tgt_y);
      end else begin
        add_query($urandom_range(65535), $urandom_range(65535));
      end
    end
  endtask

  initial begin
    tgt_x = 0;
    tgt_y = 0;
    for (int i = 0; i < NUM_REP_REGS; i++) rep_xy[i] = '0;
    rep_count = 0;
    repel_rad = RADIUS_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values, extremes of the query fields
    add_query(0, 0);
    add_query(32767, 32767);
    add_query(-32768, -32768);
    add_query(-32768, 32767);
    add_query(32767, 0);
    add_query(0, -32768);
    add_query(1, 0);
    add_query(0, -1);
    drain();

    // repulsors around a target, one sitting on the target so the field cancels
    reg_write(REG_TARGET_X, 32'd1600);
    reg_write(REG_TARGET_Y, -32'sd800);
    reg_write(REG_REP_A, {16'd64, 16'd400});
    reg_write(REG_REP_B, {-16'sd800, 16'sd1600});
    reg_write(REG_REP_C, {16'h8000, 16'h7fff});
    reg_write(REG_REP_D, {16'h7fff, 16'h8000});
    reg_write(REG_REP_COUNT, 32'hffff_fff4);
    reg_write(REG_REPEL_RADIUS, 32'hffff_7fff);
    reg_done();
    add_query(1600, -800);
    add_query(400, 64);
    add_query(1200, -800);
    add_query(800, -800);
    add_query(400, 80);
    add_query(32767, -32768);
    add_query(-32768, 32767);
    add_query(-32768, -32768);
    add_query(0, 0);
    drain();
    reg_write(REG_REP_COUNT, 32'd7);
    reg_write(REG_REPEL_RADIUS, 32'd0);
    reg_done();
    add_query(400, 64);
    add_query(1200, -800);
    add_query(-32768, 32767);
    drain();

    send_idle_pct = 8;
    recv_idle_pct = 69;
    random_config(4, 1200);
    random_queries(240);
    drain();
    random_config(3, $urandom_range(32767));
    hold_request = 1'b1;
    random_queries(240);
    drain();

    send_idle_pct = 69;
    recv_idle_pct = 8;
    random_config(0, 800);
    random_queries(240);
    drain();
    random_config(6, 32767);
    random_queries(240);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config(2, 2000);
    random_queries(240);
    send_pause = 1'b1;
    while (dir_queue.size() != 0 || in_valid) @(posedge clk);
    send_pause = 1'b0;
    drain();
    random_config(4, 0);
    random_queries(100);
    drain();
    random_config(1, 1);
    random_queries(120);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && dir_queue.size() == 0)
      $display("potential_field_direction_core_tb OK");
    else
      $display("potential_field_direction_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== potential_field_direction_core.f =====
rtl/core/pfd_pkg.sv
rtl/core/pfd_div_pipe.sv
rtl/core/pfd_isqrt_pipe.sv
rtl/core/pfd_front.sv
rtl/core/pfd_norm.sv
rtl/core/potential_field_direction_core.sv
tb/potential_field_direction_core_tb.sv
